// ===== hw/rtl/e2h_pkg.sv =====
// Shared constants, types and a helper function for the Euler pose to transform block.
package e2h_pkg;

   localparam int CordicStages = 16;
   localparam int AngleWidth   = 16;
   localparam int ShiftWidth   = 32;
   localparam int EntryWidth   = 16;
   localparam int CordicWidth  = 20;
   localparam int AngleQ16W    = 20;

   localparam logic signed [CordicWidth-1:0] CordicK    = 20'sd39797;
   localparam logic signed [AngleQ16W-1:0]   Q16Pi      = 20'sd205887;
   localparam logic signed [AngleQ16W-1:0]   Q16HalfPi  = 20'sd102944;
   localparam logic signed [EntryWidth-1:0]  Q14Max     = 16'sd16384;

   typedef logic signed [CordicWidth-1:0] cval_type;

   // One cell's payload: the three rotators plus the untouched translation.
   typedef struct packed {
      cval_type [2:0]                  x;
      cval_type [2:0]                  y;
      cval_type [2:0]                  z;
      logic [2:0]                      neg;
      logic signed [ShiftWidth-1:0]    sx;
      logic signed [ShiftWidth-1:0]    sy;
      logic signed [ShiftWidth-1:0]    sz;
   } cell_data_type;

   function automatic cval_type atan_entry(input int i);
      cval_type t;
      case (i)
         0: t = 20'sd51472;  1: t = 20'sd30386;  2: t = 20'sd16055;  3: t = 20'sd8150;
         4: t = 20'sd4091;   5: t = 20'sd2047;   6: t = 20'sd1024;   7: t = 20'sd512;
         8: t = 20'sd256;    9: t = 20'sd128;    10: t = 20'sd64;    11: t = 20'sd32;
         12: t = 20'sd16;    13: t = 20'sd8;     14: t = 20'sd4;     default: t = 20'sd2;
      endcase
      return t;
   endfunction

endpackage

// ===== hw/rtl/e2h_cordic_cell.sv =====
// One CORDIC rotation stage for three angles, with a valid/stall register.
module e2h_cordic_cell #(
   parameter int Stage = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  e2h_pkg::cell_data_type  in_data,
   output logic                    out_valid,
   input  logic                    out_stall,
   output e2h_pkg::cell_data_type  out_data
);

   logic                   valid_ff, valid_in;
   e2h_pkg::cell_data_type data_ff, data_in;

   assign in_stall = valid_ff && out_stall;

   always_comb begin
      data_in = in_data;
      for (int k = 0; k < 3; k++) begin
         if (!in_data.z[k][e2h_pkg::CordicWidth-1]) begin
            data_in.x[k] = in_data.x[k] - (in_data.y[k] >>> Stage);
            data_in.y[k] = in_data.y[k] + (in_data.x[k] >>> Stage);
            data_in.z[k] = in_data.z[k] - e2h_pkg::atan_entry(Stage);
         end else begin
            data_in.x[k] = in_data.x[k] + (in_data.y[k] >>> Stage);
            data_in.y[k] = in_data.y[k] - (in_data.x[k] >>> Stage);
            data_in.z[k] = in_data.z[k] + e2h_pkg::atan_entry(Stage);
         end
      end
      valid_in = in_stall ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (!in_stall && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/e2h_matrix.sv =====
// Matrix product pipeline: builds and rounds the nine rotation entries.
module e2h_matrix (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  e2h_pkg::cell_data_type  in_data,
   output logic                    out_valid,
   input  logic                    out_stall,
   output logic signed [e2h_pkg::EntryWidth-1:0] out_rot [9],
   output logic signed [e2h_pkg::ShiftWidth-1:0] out_x,
   output logic signed [e2h_pkg::ShiftWidth-1:0] out_y,
   output logic signed [e2h_pkg::ShiftWidth-1:0] out_z
);

   localparam int PW = 40;  // Q32 pair products
   localparam int TW = 60;  // Q48 triple products

   // Stage 1: signed sine/cosine. Stage 2: pair products. Stage 3: entries Q48.
   // Stage 4: rounded and clamped.
   logic [3:0] valid_ff;
   logic       adv;
   assign adv      = !(valid_ff[3] && out_stall);
   assign in_stall = !adv;

   logic signed [e2h_pkg::CordicWidth-1:0] s_ff [3], c_ff [3];
   logic signed [PW-1:0] czcy_ff, czsy_ff, szcx_ff, szsx_ff, szcy_ff;
   logic signed [PW-1:0] czcx_ff, szsy_ff, czsx_ff, cysx_ff, cycx_ff;
   logic signed [e2h_pkg::CordicWidth-1:0] sx2_ff, cx2_ff, sy2_ff;
   logic signed [TW-1:0] e_ff [9];
   logic signed [e2h_pkg::EntryWidth-1:0] rot_ff [9];
   logic signed [e2h_pkg::ShiftWidth-1:0] t_ff [4][3];

   function automatic logic signed [e2h_pkg::EntryWidth-1:0] to_q14(
      input logic signed [TW-1:0] v);
      logic signed [TW-1:0] r;
      r = (v + (TW'(1) <<< 33)) >>> 34;
      if (r > TW'(16384)) return e2h_pkg::Q14Max;
      if (r < -TW'(16384)) return -e2h_pkg::Q14Max;
      return r[e2h_pkg::EntryWidth-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            s_ff[k] <= in_data.neg[k] ? -in_data.y[k] : in_data.y[k];
            c_ff[k] <= in_data.neg[k] ? -in_data.x[k] : in_data.x[k];
         end
         t_ff[0][0] <= in_data.sx; t_ff[0][1] <= in_data.sy; t_ff[0][2] <= in_data.sz;
         for (int j = 1; j < 4; j++) begin
            t_ff[j] <= t_ff[j-1];
         end
         czcy_ff <= PW'(c_ff[2]) * PW'(c_ff[1]);
         czsy_ff <= PW'(c_ff[2]) * PW'(s_ff[1]);
         szcx_ff <= PW'(s_ff[2]) * PW'(c_ff[0]);
         szsx_ff <= PW'(s_ff[2]) * PW'(s_ff[0]);
         szcy_ff <= PW'(s_ff[2]) * PW'(c_ff[1]);
         czcx_ff <= PW'(c_ff[2]) * PW'(c_ff[0]);
         szsy_ff <= PW'(s_ff[2]) * PW'(s_ff[1]);
         czsx_ff <= PW'(c_ff[2]) * PW'(s_ff[0]);
         cysx_ff <= PW'(c_ff[1]) * PW'(s_ff[0]);
         cycx_ff <= PW'(c_ff[1]) * PW'(c_ff[0]);
         sx2_ff  <= s_ff[0];
         cx2_ff  <= c_ff[0];
         sy2_ff  <= s_ff[1];
         e_ff[0] <= TW'(czcy_ff) <<< 16;
         e_ff[1] <= TW'(czsy_ff) * TW'(sx2_ff) + (TW'(szcx_ff) <<< 16);
         e_ff[2] <= (TW'(szsx_ff) <<< 16) - TW'(czsy_ff) * TW'(cx2_ff);
         e_ff[3] <= -(TW'(szcy_ff) <<< 16);
         e_ff[4] <= (TW'(czcx_ff) <<< 16) - TW'(szsy_ff) * TW'(sx2_ff);
         e_ff[5] <= TW'(szsy_ff) * TW'(cx2_ff) + (TW'(czsx_ff) <<< 16);
         e_ff[6] <= TW'(sy2_ff) <<< 32;
         e_ff[7] <= -(TW'(cysx_ff) <<< 16);
         e_ff[8] <= TW'(cycx_ff) <<< 16;
         for (int k = 0; k < 9; k++) begin
            rot_ff[k] <= to_q14(e_ff[k]);
         end
      end
   end

   assign out_valid = valid_ff[3];
   assign out_rot   = rot_ff;
   assign out_x     = t_ff[3][0];
   assign out_y     = t_ff[3][1];
   assign out_z     = t_ff[3][2];

endmodule

// ===== hw/rtl/euler_to_homogeneous_transform.sv =====
// Top level: ZYX Euler pose to the upper three rows of a homogeneous transform.
//
// A request carries roll, pitch and yaw in Q3.13 radians and an x, y, z
// translation in Q16.16. The response carries the nine rotation entries
// R = Rz*Ry*Rx in Q1.14, rounded half up and clamped to plus or minus one,
// with the translation passed through unchanged.
// Both channels use valid and stall; a request moves on an edge where valid
// is high and stall is low.
// The datapath is a row of sixteen CORDIC cells, one per rotation step, all
// three angles rotating side by side, after one range-reduction register and
// followed by a four-stage product pipeline. Throughput is one request per
// cycle while the receiver does not stall; every stage holds one request.
// When a valid response is stalled, the four product stages hold together. The
// reduction register and each CORDIC cell stall only while full, so bubbles
// ahead of the product stages are squeezed out before the request port stalls.
// Reset clears every valid bit; no response is pending after reset.
module euler_to_homogeneous_transform (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [31:0] req_shift_x,
   input  logic signed [31:0] req_shift_y,
   input  logic signed [31:0] req_shift_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_rot_r0c0,
   output logic signed [15:0] rsp_rot_r0c1,
   output logic signed [15:0] rsp_rot_r0c2,
   output logic signed [15:0] rsp_rot_r1c0,
   output logic signed [15:0] rsp_rot_r1c1,
   output logic signed [15:0] rsp_rot_r1c2,
   output logic signed [15:0] rsp_rot_r2c0,
   output logic signed [15:0] rsp_rot_r2c1,
   output logic signed [15:0] rsp_rot_r2c2,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z
);

   localparam int N = e2h_pkg::CordicStages;

   logic                   v [N+1];
   logic                   st [N+1];
   e2h_pkg::cell_data_type d [N+1];

   // Range reduction register: angle to Q16, folded into plus or minus pi/2.
   logic                   red_valid_ff;
   e2h_pkg::cell_data_type red_ff, red_in;
   logic signed [15:0]     ang [3];

   assign ang[0] = req_roll_angle;
   assign ang[1] = req_pitch_angle;
   assign ang[2] = req_yaw_angle;

   always_comb begin
      logic signed [e2h_pkg::AngleQ16W-1:0] a;
      red_in = '0;
      for (int k = 0; k < 3; k++) begin
         a = {{(e2h_pkg::AngleQ16W-19){ang[k][15]}}, ang[k], 3'b000};
         red_in.neg[k] = 1'b0;
         if (a > e2h_pkg::Q16HalfPi) begin
            a = a - e2h_pkg::Q16Pi;
            red_in.neg[k] = 1'b1;
         end else if (a < -e2h_pkg::Q16HalfPi) begin
            a = a + e2h_pkg::Q16Pi;
            red_in.neg[k] = 1'b1;
         end
         red_in.x[k] = e2h_pkg::CordicK;
         red_in.y[k] = '0;
         red_in.z[k] = a;
      end
      red_in.sx = req_shift_x;
      red_in.sy = req_shift_y;
      red_in.sz = req_shift_z;
   end

   assign req_stall = red_valid_ff && st[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         red_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         red_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         red_ff <= red_in;
      end
   end

   assign v[0] = red_valid_ff;
   assign d[0] = red_ff;

   for (genvar g = 0; g < N; g++) begin : g_cell
      e2h_cordic_cell #(.Stage(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v[g]),
         .in_stall  (st[g]),
         .in_data   (d[g]),
         .out_valid (v[g+1]),
         .out_stall (st[g+1]),
         .out_data  (d[g+1])
      );
   end

   logic signed [15:0] rot [9];

   e2h_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v[N]),
      .in_stall  (st[N]),
      .in_data   (d[N]),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_rot   (rot),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z)
   );

   assign rsp_rot_r0c0 = rot[0];
   assign rsp_rot_r0c1 = rot[1];
   assign rsp_rot_r0c2 = rot[2];
   assign rsp_rot_r1c0 = rot[3];
   assign rsp_rot_r1c1 = rot[4];
   assign rsp_rot_r1c2 = rot[5];
   assign rsp_rot_r2c0 = rot[6];
   assign rsp_rot_r2c1 = rot[7];
   assign rsp_rot_r2c2 = rot[8];

`ifndef SYNTH
   // Rotation entry r0c0 never leaves the clamped range.
   a_r00_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rot_r0c0 <= 16'sd16384 && rsp_rot_r0c0 >= -16'sd16384))
      else $error("r0c0 out of range");
   // A stalled response stays valid and holds its out_x and r1c1 payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_rot_r1c1))
      else $error("stalled response changed");
   // Input stalls only when the first stage is full.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> red_valid_ff)
      else $error("spurious input stall");
`endif

endmodule
